>>> design/emsu_pkg.sv
// Package with the constants, widths and register codes of the synapse update block.
package emsu_pkg;

  localparam int SYNAPSES  = 256;
  localparam int SYN_IDX_W = $clog2(SYNAPSES);

  localparam int Q_W       = 16;
  localparam int POT_W     = 32;
  localparam int SYN_IN_W  = 8;
  localparam int ENTRY_W   = POT_W + 2 * Q_W;

  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_RATE_E   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEAK_E   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_W   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LEAK_PSP = 3'd3;

  localparam logic [Q_W-1:0] RST_RATE_E   = 16'd6554;
  localparam logic [Q_W-1:0] RST_LEAK_E   = 16'd655;
  localparam logic [Q_W-1:0] RST_RATE_W   = 16'd6554;
  localparam logic [Q_W-1:0] RST_LEAK_PSP = 16'd6554;

  localparam logic [Q_W:0] Q_ONE = 17'h10000;

  typedef struct packed {
    logic [POT_W-1:0] potential;
    logic [Q_W-1:0]   weight;
    logic [Q_W-1:0]   elig;
  } syn_entry_t;

endpackage

>>> design/eligibility_modulated_synapse_update_top.sv
// Top level of the three-factor eligibility-trace synapse update block.
//
//   channel | direction | ports                                         | handshake
//   --------+-----------+-----------------------------------------------+-------------------
//   in      | request   | in_synapse_index, in_presyn_activity,         | in_valid/in_ready
//           |           | in_modulation_on                              |
//   out     | result    | out_index, out_potential, out_weight_out      | out_valid/out_ready
//   cfg     | write     | cfg_index, cfg_wdata                          | cfg_we, no wait
//
// Each request runs from acceptance to a loaded result as follows: the
// synapse memory is read at the accepting edge, six registered steps of the
// arithmetic chain follow (the eligibility, weight and potential products are
// dependent and each gets its own step), and the final step does the
// write-back and output load. The next request is taken in the idle state
// after write-back, even while the previous result still waits in the output
// register; no request is taken before the last one is written back.
// Reset clears the configuration to its defaults and the per-entry valid
// bits at once, so every synapse reads as zero until it is first written.
// A stalled output holds the finished request in the last step; the
// write-back happens in the same cycle that the result enters the register.
module eligibility_modulated_synapse_update_top
  import emsu_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,

  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [SYN_IN_W-1:0]     in_synapse_index,
  input  logic signed [Q_W-1:0]   in_presyn_activity,
  input  logic                    in_modulation_on,

  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [SYN_IN_W-1:0]     out_index,
  output logic signed [POT_W-1:0] out_potential,
  output logic [Q_W-1:0]          out_weight_out,

  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [Q_W-1:0]          cfg_wdata
);

  // Sequencer codes: one per step of the update.
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_LOAD = 4'd1;
  localparam logic [3:0] S_ENEW = 4'd2;
  localparam logic [3:0] S_T    = 4'd3;
  localparam logic [3:0] S_W    = 4'd4;
  localparam logic [3:0] S_WNEW = 4'd5;
  localparam logic [3:0] S_ADD  = 4'd6;
  localparam logic [3:0] S_FIN  = 4'd7;

  logic [3:0] state_r, state_nxt;

  // Configuration registers.
  logic [Q_W-1:0] rate_e_r, leak_e_r, rate_w_r, leak_psp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_e_r   <= RST_RATE_E;
      leak_e_r   <= RST_LEAK_E;
      rate_w_r   <= RST_RATE_W;
      leak_psp_r <= RST_LEAK_PSP;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_RATE_E:   rate_e_r   <= cfg_wdata;
        CFG_LEAK_E:   leak_e_r   <= cfg_wdata;
        CFG_RATE_W:   rate_w_r   <= cfg_wdata;
        CFG_LEAK_PSP: leak_psp_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Synapse memory: eligibility, weight and potential share one entry.
  // The valid bits stand in for the all-zero reset of the memory.
  syn_entry_t           mem [SYNAPSES];
  logic [SYNAPSES-1:0]  vld_r;
  syn_entry_t           mem_rd_r;
  logic                 vld_rd_r;
  logic                 mem_we;
  syn_entry_t           mem_wdata;
  logic [SYN_IDX_W-1:0] rd_addr;

  // Request held for the duration of the update.
  logic [SYN_IN_W-1:0]   idx_r;
  logic signed [Q_W-1:0] act_r;
  logic                  mod_r;
  logic                  pos_r;

  // Datapath registers.
  logic [Q_W-1:0]          e_r, w_r, e_new_r, w_new_r;
  logic signed [POT_W-1:0] p_r, p1_r;
  logic [2*Q_W:0]          e_prod_r;
  logic signed [POT_W+Q_W:0] p_prod_r;
  logic [2*Q_W:0]          t_prod_r;
  logic [2*Q_W-1:0]        tw_prod_r;
  logic signed [2*Q_W:0]   a_prod_r;

  // Output register.
  logic                    out_valid_r;
  logic [SYN_IN_W-1:0]     out_index_r;
  logic signed [POT_W-1:0] out_pot_r;
  logic [Q_W-1:0]          out_w_r;

  logic accept;
  logic out_load;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_load = (state_r == S_FIN) && (!out_valid_r || out_ready);
  assign mem_we   = out_load;
  assign rd_addr  = in_synapse_index[SYN_IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[idx_r[SYN_IDX_W-1:0]] <= mem_wdata;
    end
    if (accept) begin
      mem_rd_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      vld_rd_r <= 1'b0;
    end else begin
      if (mem_we) begin
        vld_r[idx_r[SYN_IDX_W-1:0]] <= 1'b1;
      end
      if (accept) begin
        vld_rd_r <= vld_r[rd_addr];
      end
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (accept) state_nxt = S_LOAD;
      S_LOAD: state_nxt = S_ENEW;
      S_ENEW: state_nxt = S_T;
      S_T:    state_nxt = S_W;
      S_W:    state_nxt = S_WNEW;
      S_WNEW: state_nxt = S_ADD;
      S_ADD:  state_nxt = S_FIN;
      S_FIN:  if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Combinational pieces of each step.
  syn_entry_t              rd_entry;
  logic [Q_W:0]            e_mul_a;
  logic [Q_W-1:0]          e_mul_b;
  logic [Q_W:0]            e_sum;
  logic signed [POT_W+Q_W:0] p_dec_full;
  logic signed [POT_W+1:0] p1_full;
  logic [Q_W:0]            w_sum;
  logic signed [2*Q_W:0]   a_bias;
  logic signed [POT_W+1:0] pot_sum;
  logic signed [POT_W-1:0] pot_sat;

  assign rd_entry = vld_rd_r ? mem_rd_r : '0;
  assign e_mul_a  = pos_r ? (Q_ONE - {1'b0, rd_entry.elig}) : {1'b0, rd_entry.elig};
  assign e_mul_b  = pos_r ? rate_e_r : leak_e_r;

  // The rise step is below one minus e, so the sum never leaves 16 bits;
  // the clamp guards the carry bit all the same.
  assign e_sum = pos_r ? ({1'b0, e_r} + e_prod_r[2*Q_W:Q_W])
                       : ({1'b0, e_r} - e_prod_r[2*Q_W:Q_W]);

  // Division by a power of two rounded toward zero: bias negative values.
  assign p_dec_full = (p_prod_r + (p_prod_r[POT_W+Q_W] ? 49'sd65535 : 49'sd0)) >>> Q_W;
  assign p1_full    = {{2{p_r[POT_W-1]}}, p_r} - p_dec_full[POT_W+1:0];

  assign w_sum = {1'b0, w_r} + {1'b0, tw_prod_r[2*Q_W-1:Q_W]};

  assign a_bias  = (a_prod_r + (a_prod_r[2*Q_W] ? 33'sd4095 : 33'sd0)) >>> 12;
  assign pot_sum = {{2{p1_r[POT_W-1]}}, p1_r} + {a_bias[2*Q_W], a_bias};

  always_comb begin
    if (pot_sum[POT_W+1] && !pot_sum[POT_W-1]) begin
      pot_sat = {1'b1, {(POT_W-1){1'b0}}};
    end else if (!pot_sum[POT_W+1] && (pot_sum[POT_W] || pot_sum[POT_W-1])) begin
      pot_sat = {1'b0, {(POT_W-1){1'b1}}};
    end else begin
      pot_sat = pot_sum[POT_W-1:0];
    end
  end

  always_comb begin
    mem_wdata.elig      = e_new_r;
    mem_wdata.weight    = w_new_r;
    mem_wdata.potential = pot_sat;
  end

  // Datapath registers; no reset needed on payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      idx_r <= in_synapse_index;
      act_r <= in_presyn_activity;
      mod_r <= in_modulation_on;
      pos_r <= !in_presyn_activity[Q_W-1] && (in_presyn_activity != '0);
    end
    case (state_r)
      S_LOAD: begin
        e_r      <= rd_entry.elig;
        w_r      <= rd_entry.weight;
        p_r      <= rd_entry.potential;
        e_prod_r <= e_mul_a * {1'b0, e_mul_b};
      end
      S_ENEW: begin
        e_new_r  <= e_sum[Q_W] ? {Q_W{1'b1}} : e_sum[Q_W-1:0];
        p_prod_r <= p_r * $signed({1'b0, leak_psp_r});
      end
      S_T: begin
        t_prod_r <= (Q_ONE - {1'b0, w_r}) * {1'b0, e_new_r};
        p1_r     <= p1_full[POT_W-1:0];
      end
      S_W: begin
        tw_prod_r <= t_prod_r[2*Q_W-1:Q_W] * rate_w_r;
      end
      S_WNEW: begin
        if (mod_r) begin
          w_new_r <= w_sum[Q_W] ? {Q_W{1'b1}} : w_sum[Q_W-1:0];
        end else begin
          w_new_r <= w_r;
        end
      end
      S_ADD: begin
        a_prod_r <= $signed({1'b0, w_new_r}) * act_r;
      end
      default: ;
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_index_r <= idx_r;
      out_pot_r   <= pot_sat;
      out_w_r     <= w_new_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_index      = out_index_r;
  assign out_potential  = out_pot_r;
  assign out_weight_out = out_w_r;

`ifndef ASSERT_OFF
  a_wb_only_final: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == S_FIN))
    else $error("synapse memory written outside the final step");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_LOAD))
    else $error("accepted request did not start the memory load");

  a_wb_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |=> (out_valid_r && out_w_r == $past(w_new_r)))
    else $error("write-back without matching output load");

  a_no_mod_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ADD && !mod_r) |-> (w_new_r == w_r))
    else $error("weight changed without modulation");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && out_valid_r && !out_ready) |=> (state_r == S_FIN))
    else $error("final step left while output stalled");
`endif

endmodule

>>> test/tb_eligibility_modulated_synapse_update_top.sv
// Self-checking testbench for the eligibility-modulated synapse update block.
`timescale 1ns / 100ps

module tb_eligibility_modulated_synapse_update_top;
  import emsu_pkg::*;

  // The run stops here even if the block hangs. A correct run needs about
  // 1600 requests, so this leaves a wide margin.
  localparam int CYCLE_LIMIT = 1_000_000;
  // Register index past the end of the list. The block must ignore writes to it.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd6;
  // Full-scale steps per synapse in the long drive phase; enough to build
  // large potentials of both signs.
  localparam int RAIL_STEPS = 250;
  localparam int RANDOM_STEPS = 300;

  typedef struct packed {
    logic [SYN_IN_W-1:0]   idx;
    logic signed [Q_W-1:0] act;
    logic                  mod;
  } syn_step_t;

  typedef struct packed {
    logic [SYN_IN_W-1:0]     idx;
    logic signed [POT_W-1:0] pot;
    logic [Q_W-1:0]          wgt;
  } syn_update_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [SYN_IN_W-1:0]     in_synapse_index = '0;
  logic signed [Q_W-1:0]   in_presyn_activity = '0;
  logic                    in_modulation_on = 1'b0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [SYN_IN_W-1:0]     out_index;
  logic signed [POT_W-1:0] out_potential;
  logic [Q_W-1:0]          out_weight_out;
  logic                    cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [Q_W-1:0]          cfg_wdata = '0;

  eligibility_modulated_synapse_update_top u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_synapse_index   (in_synapse_index),
    .in_presyn_activity (in_presyn_activity),
    .in_modulation_on   (in_modulation_on),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_index          (out_index),
    .out_potential      (out_potential),
    .out_weight_out     (out_weight_out),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  // Mirror of the block's configuration and of its three per-synapse stores.
  logic [Q_W-1:0]          rate_e_q;
  logic [Q_W-1:0]          leak_e_q;
  logic [Q_W-1:0]          rate_w_q;
  logic [Q_W-1:0]          leak_psp_q;
  logic [Q_W-1:0]          elig_mem [SYNAPSES];
  logic [Q_W-1:0]          wgt_mem [SYNAPSES];
  logic signed [POT_W-1:0] pot_mem [SYNAPSES];

  // Requests waiting to be driven, and the updates the block still owes us.
  syn_step_t   step_queue[$];
  syn_update_t expected_updates[$];

  int unsigned cycle_count = 0;
  int unsigned error_count = 0;
  int unsigned requests_sent = 0;
  int unsigned updates_checked = 0;
  bit          req_taken = 1'b0;
  syn_step_t   next_step;
  syn_update_t want;

  initial begin
    forever #5 clk = ~clk;
  end

  // Random back-pressure and gaps. In the first quarter of each repeating window
  // of cycle_count neither side idles, so the block also runs at full rate.
  function automatic bit take_break();
    if ((cycle_count % 6000) < 1500) return 1'b0;
    return $urandom_range(99) < 26;
  endfunction

  // Advances one synapse by one time step in the mirror and returns the
  // update that the block must report for it.
  function automatic syn_update_t advance_synapse(logic [SYN_IN_W-1:0] idx,
                                                  logic signed [Q_W-1:0] act,
                                                  logic mod);
    int unsigned       slot;
    longint unsigned   elig;
    longint unsigned   wgt;
    longint unsigned   gain;
    longint            pot;
    longint            leak_amt;
    longint            drive;
    syn_update_t       upd;
    slot = idx % SYNAPSES;

    // Positive activity pulls the trace toward one; zero or negative decays it.
    elig = elig_mem[slot];
    if (act > 0) begin
      elig = elig + (((65536 - elig) * rate_e_q) >> 16);
    end else begin
      elig = elig - ((elig * leak_e_q) >> 16);
    end
    if (elig > 65535) elig = 65535;
    elig_mem[slot] = 16'(elig);

    // The weight only learns while the modulation gate is open.
    wgt = wgt_mem[slot];
    if (mod) begin
      gain = ((65536 - wgt) * elig) >> 16;
      wgt = wgt + ((gain * rate_w_q) >> 16);
      if (wgt > 65535) wgt = 65535;
    end
    wgt_mem[slot] = 16'(wgt);

    // Leak and drive are both truncated toward zero before the rails apply.
    pot = pot_mem[slot];
    leak_amt = (pot * longint'(leak_psp_q)) / 65536;
    pot = pot - leak_amt;
    drive = (longint'(wgt) * longint'(act)) / 4096;
    pot = pot + drive;
    if (pot > 64'sd2147483647) pot = 64'sd2147483647;
    if (pot < -64'sd2147483648) pot = -64'sd2147483648;
    pot_mem[slot] = 32'(pot);

    upd.idx = idx;
    upd.pot = 32'(pot);
    upd.wgt = 16'(wgt);
    return upd;
  endfunction

  task automatic queue_step(logic [SYN_IN_W-1:0] idx, logic signed [Q_W-1:0] act,
                            logic mod);
    syn_step_t s;
    s.idx = idx;
    s.act = act;
    s.mod = mod;
    step_queue.push_back(s);
  endtask

  // Most random requests revisit a handful of synapses so that traces,
  // weights and potentials build up; the rest spread over every index.
  // Activity favors the rails, zero and small magnitudes.
  task automatic queue_random_steps(int count);
    logic [SYN_IN_W-1:0]   idx;
    logic signed [Q_W-1:0] act;
    int unsigned           pick;
    for (int i = 0; i < count; i++) begin
      idx = ($urandom_range(99) < 70) ? 8'($urandom_range(15)) : 8'($urandom_range(255));
      pick = $urandom_range(99);
      if (pick < 15) begin
        act = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
      end else if (pick < 30) begin
        act = '0;
      end else if (pick < 50) begin
        act = 16'($urandom_range(255));
        if ($urandom_range(1)) act = -act;
      end else begin
        act = 16'($urandom);
      end
      queue_step(idx, act, 1'($urandom_range(1)));
    end
  endtask

  // Register writes happen only with the block idle, so the mirror can take
  // the new value at once.
  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [Q_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_RATE_E:   rate_e_q = val;
      CFG_LEAK_E:   leak_e_q = val;
      CFG_RATE_W:   rate_w_q = val;
      CFG_LEAK_PSP: leak_psp_q = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    while (step_queue.size() != 0 || in_valid || expected_updates.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Request driver: a new request goes out at the falling edge once the
  // previous one was accepted, unless a random gap is drawn.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || req_taken) begin
      req_taken = 1'b0;
      if (step_queue.size() != 0 && !take_break()) begin
        next_step = step_queue.pop_front();
        in_valid <= 1'b1;
        in_synapse_index <= next_step.idx;
        in_presyn_activity <= next_step.act;
        in_modulation_on <= next_step.mod;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result side back-pressure.
  always @(negedge clk) begin
    out_ready <= !take_break();
  end

  // Both handshakes are sampled at the rising edge. An accepted request is
  // run through the mirror right away; each result is checked against the
  // oldest update still owed.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d updates outstanding",
               cycle_count, expected_updates.size());
      $display("status: fail");
      $finish;
    end
    if (rst_n) begin
      if (in_valid && in_ready) begin
        expected_updates.push_back(advance_synapse(in_synapse_index, in_presyn_activity,
                                                   in_modulation_on));
        requests_sent++;
        req_taken = 1'b1;
      end
      if (out_valid && out_ready) begin
        if (expected_updates.size() == 0) begin
          $error("result for synapse %0d arrived with no request outstanding", out_index);
          error_count++;
        end else begin
          want = expected_updates.pop_front();
          if (out_index !== want.idx) begin
            $error("out_index: expected %0d, got %0d", want.idx, out_index);
            error_count++;
          end
          if (out_potential !== want.pot) begin
            $error("out_potential: expected %0d, got %0d", want.pot, out_potential);
            error_count++;
          end
          if (out_weight_out !== want.wgt) begin
            $error("out_weight_out: expected %0d, got %0d", want.wgt, out_weight_out);
            error_count++;
          end
          updates_checked++;
        end
      end
    end
  end

  initial begin : run_phases
    rate_e_q = RST_RATE_E;
    leak_e_q = RST_LEAK_E;
    rate_w_q = RST_RATE_W;
    leak_psp_q = RST_LEAK_PSP;
    for (int s = 0; s < SYNAPSES; s++) begin
      elig_mem[s] = '0;
      wgt_mem[s] = '0;
      pot_mem[s] = '0;
    end

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed requests with the reset configuration: both activity rails,
    // zero activity (which must decay the trace), plus and minus one, both
    // ends of the index range and alternating bit patterns, with the gate
    // open and closed.
    queue_step(8'd0, 16'sh7fff, 1'b1);
    queue_step(8'd0, 16'sh7fff, 1'b1);
    queue_step(8'd0, 16'sh0000, 1'b1);
    queue_step(8'd0, 16'sh8000, 1'b0);
    queue_step(8'd0, 16'sh8000, 1'b1);
    queue_step(8'd255, 16'sh8000, 1'b1);
    queue_step(8'd255, 16'sh7fff, 1'b1);
    queue_step(8'd255, 16'sh0001, 1'b0);
    queue_step(8'd255, 16'sh0000, 1'b0);
    queue_step(8'd128, 16'shffff, 1'b1);
    queue_step(8'd128, 16'sh0001, 1'b1);
    queue_step(8'd1, 16'sh0000, 1'b0);
    queue_step(8'd170, 16'sh5555, 1'b1);
    queue_step(8'd85, 16'shaaaa, 1'b0);
    queue_step(8'd170, 16'shaaaa, 1'b1);
    queue_step(8'd85, 16'sh5555, 1'b1);
    queue_step(8'd127, 16'sh7fff, 1'b1);
    queue_step(8'd127, 16'sh7fff, 1'b1);
    queue_step(8'd127, 16'sh7fff, 1'b1);
    queue_step(8'd127, 16'sh0000, 1'b1);
    wait_drained();

    // Every rate and leak at its maximum; also poke the unused index, which
    // must leave the configuration alone.
    write_cfg(CFG_RATE_E, 16'hffff);
    write_cfg(CFG_LEAK_E, 16'hffff);
    write_cfg(CFG_RATE_W, 16'hffff);
    write_cfg(CFG_LEAK_PSP, 16'hffff);
    write_cfg(CFG_SPARE, 16'h1234);
    queue_random_steps(RANDOM_STEPS);
    wait_drained();

    // Everything frozen: no learning, no decay, the potential only integrates.
    write_cfg(CFG_RATE_E, 16'h0000);
    write_cfg(CFG_LEAK_E, 16'h0000);
    write_cfg(CFG_RATE_W, 16'h0000);
    write_cfg(CFG_LEAK_PSP, 16'h0000);
    queue_random_steps(RANDOM_STEPS / 2);
    wait_drained();

    // A few arbitrary settings.
    for (int p = 0; p < 3; p++) begin
      write_cfg(CFG_RATE_E, 16'($urandom));
      write_cfg(CFG_LEAK_E, 16'($urandom));
      write_cfg(CFG_RATE_W, 16'($urandom));
      write_cfg(CFG_LEAK_PSP, 16'($urandom));
      queue_random_steps(RANDOM_STEPS * 2 / 3);
      wait_drained();
    end

    // Drive one synapse up and one down: fastest learning, no leak and
    // full-scale activity, so both potentials grow large.
    write_cfg(CFG_RATE_E, 16'hffff);
    write_cfg(CFG_RATE_W, 16'hffff);
    write_cfg(CFG_LEAK_PSP, 16'h0000);
    for (int k = 0; k < RAIL_STEPS; k++) begin
      queue_step(8'd7, 16'sh7fff, 1'b1);
      queue_step(8'd200, 16'sh8000, 1'b1);
    end
    wait_drained();

    // Let the large potentials leak back with the strongest leak.
    write_cfg(CFG_LEAK_PSP, 16'hffff);
    for (int k = 0; k < 10; k++) begin
      queue_step(8'd7, 16'sh0000, 1'($urandom_range(1)));
      queue_step(8'd200, 16'sh7fff, 1'($urandom_range(1)));
    end
    wait_drained();

    repeat (20) @(posedge clk);
    if (expected_updates.size() != 0) begin
      $error("%0d expected updates never arrived", expected_updates.size());
      error_count++;
    end
    $display("ran %0d synapse steps across reset, extreme, frozen and random settings",
             requests_sent);
    $display("checked %0d updates including long full-scale drive runs, %0d errors",
             updates_checked, error_count);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> eligibility_modulated_synapse_update_top.f
design/emsu_pkg.sv
design/eligibility_modulated_synapse_update_top.sv
test/tb_eligibility_modulated_synapse_update_top.sv
